/* hw/rtl/u2u8_pkg.sv */
// Package: constants, job type and byte builders for the UTF-16 to UTF-8 stream.
package u2u8_pkg;

  localparam int unsigned MaxBytes   = 7;
  localparam int unsigned CountW     = $clog2(MaxBytes + 1);
  localparam int unsigned IdxW       = $clog2(MaxBytes);
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic [5:0]  HighPrefix = 6'b110110;  // 0xD800..0xDBFF
  localparam logic [5:0]  LowPrefix  = 6'b110111;  // 0xDC00..0xDFFF
  localparam logic [20:0] PairBase   = 21'h10000;
  localparam logic [7:0]  Lead2      = 8'hC0;
  localparam logic [7:0]  Lead3      = 8'hE0;
  localparam logic [7:0]  Lead4      = 8'hF0;
  localparam logic [7:0]  ContMark   = 8'h80;
  localparam logic [7:0]  TermByte   = 8'h00;

  // One job: bytes are shifted in, so the first byte sits at index nbytes-1.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CountW-1:0]        nbytes;
    logic                     term;
  } u2u8_job_t;

  function automatic u2u8_job_t push_byte(u2u8_job_t job, logic [7:0] b);
    u2u8_job_t r;
    r        = job;
    r.bytes  = {job.bytes[MaxBytes-2:0], b};
    r.nbytes = job.nbytes + CountW'(1);
    return r;
  endfunction

  function automatic u2u8_job_t push_three(u2u8_job_t job, logic [15:0] u);
    u2u8_job_t r;
    r = push_byte(job, Lead3 | {4'h0, u[15:12]});
    r = push_byte(r, ContMark | {2'b00, u[11:6]});
    r = push_byte(r, ContMark | {2'b00, u[5:0]});
    return r;
  endfunction

endpackage

/* hw/rtl/u2u8_in_if.sv */
// Input channel: one UTF-16 code unit per item.
interface u2u8_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        last_unit;

  modport source (output valid, output code_unit, output last_unit, input ready);
  modport sink   (input valid, input code_unit, input last_unit, output ready);
endinterface

/* hw/rtl/u2u8_out_if.sv */
// Output channel: one UTF-8 byte per item.
interface u2u8_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       string_end;
  logic       run_last;

  modport source (output valid, output out_byte, output string_end, output run_last,
                  input ready);
  modport sink   (input valid, input out_byte, input string_end, input run_last,
                  output ready);
endinterface

/* hw/rtl/u2u8_front.sv */
// Front end: surrogate tracking and expansion of each code unit into a byte job.
module u2u8_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [15:0]          code_unit_i,
  input  logic                 last_unit_i,
  input  logic                 q_full_i,
  output logic                 in_ready_o,
  output logic                 push_o,
  output u2u8_pkg::u2u8_job_t  job_o
);

  logic [9:0]  held_high_q, held_high_d;
  logic        held_valid_q, held_valid_d;
  logic        stopped_q, stopped_d;

  logic        accept;
  logic        is_high, is_low;
  logic [20:0] pair_code;
  u2u8_pkg::u2u8_job_t job;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign is_high    = code_unit_i[15:10] == u2u8_pkg::HighPrefix;
  assign is_low     = code_unit_i[15:10] == u2u8_pkg::LowPrefix;
  assign pair_code  = u2u8_pkg::PairBase + {1'b0, held_high_q, code_unit_i[9:0]};

  always_comb begin
    job          = '0;
    held_high_d  = held_high_q;
    held_valid_d = held_valid_q;
    stopped_d    = stopped_q;
    if (stopped_q) begin
      // string already ended by a zero unit: swallow until the buffer's last unit
      if (last_unit_i) begin
        stopped_d = 1'b0;
      end
    end else if (held_valid_q && is_low) begin
      job = u2u8_pkg::push_byte(job, u2u8_pkg::Lead4 | {5'b0, pair_code[20:18]});
      job = u2u8_pkg::push_byte(job, u2u8_pkg::ContMark | {2'b0, pair_code[17:12]});
      job = u2u8_pkg::push_byte(job, u2u8_pkg::ContMark | {2'b0, pair_code[11:6]});
      job = u2u8_pkg::push_byte(job, u2u8_pkg::ContMark | {2'b0, pair_code[5:0]});
      held_valid_d = 1'b0;
      held_high_d  = '0;
      if (last_unit_i) begin
        job      = u2u8_pkg::push_byte(job, u2u8_pkg::TermByte);
        job.term = 1'b1;
      end
    end else begin
      if (held_valid_q) begin
        // unpaired high surrogate goes out on its own
        job = u2u8_pkg::push_three(job, {u2u8_pkg::HighPrefix, held_high_q});
        held_valid_d = 1'b0;
        held_high_d  = '0;
      end
      if (code_unit_i == 16'h0000) begin
        stopped_d = !last_unit_i;
      end else if (code_unit_i[15:7] == '0) begin
        job = u2u8_pkg::push_byte(job, code_unit_i[7:0]);
      end else if (code_unit_i[15:11] == '0) begin
        job = u2u8_pkg::push_byte(job, u2u8_pkg::Lead2 | {3'b0, code_unit_i[10:6]});
        job = u2u8_pkg::push_byte(job, u2u8_pkg::ContMark | {2'b0, code_unit_i[5:0]});
      end else if (is_high && !last_unit_i) begin
        held_high_d  = code_unit_i[9:0];
        held_valid_d = 1'b1;
      end else begin
        job = u2u8_pkg::push_three(job, code_unit_i);
      end
      if (code_unit_i == 16'h0000 || last_unit_i) begin
        job      = u2u8_pkg::push_byte(job, u2u8_pkg::TermByte);
        job.term = 1'b1;
      end
    end
  end

  assign push_o = accept && (job.nbytes != '0);
  assign job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_high_q  <= '0;
      held_valid_q <= 1'b0;
      stopped_q    <= 1'b0;
    end else if (accept) begin
      held_high_q  <= held_high_d;
      held_valid_q <= held_valid_d;
      stopped_q    <= stopped_d;
    end
  end

endmodule

/* hw/rtl/u2u8_queue.sv */
// Short job queue between front end and byte serializer.
module u2u8_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  u2u8_pkg::u2u8_job_t  push_job_i,
  input  logic                 pop_i,
  output u2u8_pkg::u2u8_job_t  pop_job_o,
  output logic                 full_o,
  output logic                 empty_o
);

  u2u8_pkg::u2u8_job_t mem_q [u2u8_pkg::QueueDepth];

  logic [u2u8_pkg::QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [u2u8_pkg::QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [u2u8_pkg::QCntW-1:0] count_q, count_d;
  logic                       do_push, do_pop;

  assign full_o    = count_q == u2u8_pkg::QCntW'(u2u8_pkg::QueueDepth);
  assign empty_o   = count_q == '0;
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_job_o = mem_q[rd_ptr_q];

  function automatic logic [u2u8_pkg::QPtrW-1:0] ptr_inc(logic [u2u8_pkg::QPtrW-1:0] p);
    return (p == u2u8_pkg::QPtrW'(u2u8_pkg::QueueDepth - 1)) ? '0 : p + u2u8_pkg::QPtrW'(1);
  endfunction

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + u2u8_pkg::QCntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - u2u8_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* hw/rtl/u2u8_back.sv */
// Back end: serializes one job into output bytes, one per cycle while out_ready_i is high.
module u2u8_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  u2u8_pkg::u2u8_job_t  q_job_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic                 string_end_o,
  output logic                 run_last_o
);

  u2u8_pkg::u2u8_job_t         cur_q, cur_d;
  logic [u2u8_pkg::IdxW-1:0]   idx_q, idx_d;
  logic                        busy_q, busy_d;
  logic                        at_end, done;

  assign at_end = idx_q == '0;
  assign done   = busy_q && out_ready_i && at_end;
  // load the next job while the last byte of the current one goes out
  assign q_pop_o = !q_empty_i && (!busy_q || done);

  always_comb begin
    cur_d  = cur_q;
    idx_d  = idx_q;
    busy_d = busy_q;
    if (q_pop_o) begin
      cur_d  = q_job_i;
      idx_d  = u2u8_pkg::IdxW'(q_job_i.nbytes - u2u8_pkg::CountW'(1));
      busy_d = 1'b1;
    end else if (done) begin
      busy_d = 1'b0;
    end else if (busy_q && out_ready_i) begin
      idx_d = idx_q - u2u8_pkg::IdxW'(1);
    end
  end

  assign out_valid_o  = busy_q;
  assign out_byte_o   = cur_q.bytes[idx_q];
  assign run_last_o   = at_end;
  assign string_end_o = at_end && cur_q.term;

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      busy_q <= busy_d;
    end
  end

endmodule

/* hw/rtl/utf16_to_utf8_stream.sv */
// Top level: streaming UTF-16 to UTF-8 transcoder.
//
// in_i carries one UTF-16 code unit per item, with last_unit on the final
// unit of a string buffer. out_o carries one UTF-8 byte per item; run_last
// marks the final byte caused by an input unit and string_end marks the
// zero terminator sent after a zero unit or after the last unit.
// A high surrogate that is not the last unit is held until the next unit; a
// following low surrogate makes a 4-byte sequence, otherwise the held unit goes out as 3 bytes.
// After a zero unit that is not last, units are dropped up to the last unit.
// With the serializer idle, an accepted unit's job is written into the queue,
// then loaded into the serializer register, which puts its first byte on out_o.
// Throughput: the byte serializer sends one byte per cycle while out_o.ready is
// high and jobs are queued; a unit makes 1 to 7 bytes, and a unit that makes
// no byte pushes no job. The front end takes a unit every cycle while the
// two-entry job queue has room, so it keeps working while out_o stalls.
// Reset clears the held surrogate, the stopped flag, the queue and the
// serializer; nothing is in flight after reset. When out_o.ready is low the
// current byte holds, then the queue fills and in_i.ready drops.
module utf16_to_utf8_stream (
  input  logic clk_i,
  input  logic rst_ni,
  u2u8_in_if.sink    in_i,
  u2u8_out_if.source out_o
);

  u2u8_pkg::u2u8_job_t push_job;
  u2u8_pkg::u2u8_job_t pop_job;
  logic                push, pop, q_full, q_empty;

  u2u8_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .code_unit_i (in_i.code_unit),
    .last_unit_i (in_i.last_unit),
    .q_full_i    (q_full),
    .in_ready_o  (in_i.ready),
    .push_o      (push),
    .job_o       (push_job)
  );

  u2u8_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .pop_job_o  (pop_job),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  u2u8_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_job_i      (pop_job),
    .q_pop_o      (pop),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_byte_o   (out_o.out_byte),
    .string_end_o (out_o.string_end),
    .run_last_o   (out_o.run_last)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("job pushed into full queue");

  a_job_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (push_job.nbytes != '0) &&
             (push_job.nbytes <= u2u8_pkg::CountW'(u2u8_pkg::MaxBytes)))
    else $error("job byte count out of range");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.string_end |-> out_o.run_last && out_o.out_byte == 8'h00)
    else $error("terminator not last byte of its unit");

  a_term_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && push_job.term |-> push_job.bytes[0] == u2u8_pkg::TermByte)
    else $error("terminated job does not end in zero byte");
`endif

endmodule
